>>> hdl/rgbpal_pkg.sv
// Shared types, constants and colour helpers for the RGBA5551 palette builder.
`default_nettype none

package rgbpal_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int PMAX_W            = 9;
    localparam logic [PMAX_W-1:0] PMAX_RESET = 9'd256;
    localparam int FIFO_DEPTH        = 2;
    localparam int CHAN_W            = 8;
    localparam int WORD_W            = 16;
    localparam int IDX_OUT_W         = 8;
    localparam int USED_OUT_W        = 9;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MISS,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]  color_index;
        logic [WORD_W-1:0]     packed_color;
        logic                  newly_added;
        logic                  full_error;
        logic [USED_OUT_W-1:0] entries_used;
    } res_t;

    // v*31/255, truncated: x/255 == (x + 1 + (x >> 8)) >> 8 for x below 65535
    function automatic logic [4:0] scale5(input logic [CHAN_W-1:0] v);
        logic [13:0] prod;
        logic [13:0] sum;
        prod = ({6'd0, v} << 5) - {6'd0, v};
        sum  = prod + 14'd1 + (prod >> 8);
        return sum[12:8];
    endfunction

endpackage

`default_nettype wire

>>> hdl/rgbpal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rgbpal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/rgbpal_front.sv
// Front end: takes pixel requests and packs them into RGBA5551 words.
`default_nettype none

module rgbpal_front (
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0] red,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0] green,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0] blue,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0] alpha,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [rgbpal_pkg::WORD_W-1:0]    q_wdata
);
    import rgbpal_pkg::*;

    assign full    = q_full;
    assign q_push  = push & ~q_full;
    assign q_wdata = {scale5(red), scale5(green), scale5(blue), (alpha != '0)};

endmodule

`default_nettype wire

>>> hdl/rgbpal_fifo.sv
// Short register queue between the front end and the palette search.
`default_nettype none

module rgbpal_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = slot_reg[rptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rgbpal_back.sv
// Back end: linear palette search, append on miss, result register.
`default_nettype none

module rgbpal_back #(
    parameter int PALETTE_DEPTH = rgbpal_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rgbpal_pkg::PMAX_W-1:0] palette_max,
    input  wire logic                          q_empty,
    input  wire logic [rgbpal_pkg::WORD_W-1:0] q_rdata,
    output logic                               q_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output rgbpal_pkg::res_t                   res
);
    import rgbpal_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > PMAX_W) ? CNT_W : PMAX_W;

    bk_state_t         state_reg, state_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    res_t              res_reg, res_next;
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              ram_we;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              is_full;
    logic              scan_last;

    rgbpal_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (word_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // limit is min(palette_max, depth); count never exceeds depth
    assign is_full   = (CMP_W'(count_reg) >= CMP_W'(palette_max)) ||
                       (CMP_W'(count_reg) >= CMP_W'(PALETTE_DEPTH));
    assign scan_last = ((CNT_W'(cmp_idx_reg) + 1'b1) >= count_reg);
    assign empty     = ~out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        cmp_idx_next   = cmp_idx_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~pop;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        rd_addr        = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    word_next    = q_rdata;
                    cmp_idx_next = '0;
                    state_next   = (count_reg == '0) ? BK_MISS : BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                // rd_data holds the entry at cmp_idx_reg
                if (rd_data == word_reg)
                begin
                    res_next.color_index  = IDX_OUT_W'(cmp_idx_reg);
                    res_next.packed_color = word_reg;
                    res_next.newly_added  = 1'b0;
                    res_next.full_error   = 1'b0;
                    res_next.entries_used = USED_OUT_W'(count_reg);
                    state_next            = BK_EMIT;
                end
                else if (scan_last)
                begin
                    state_next = BK_MISS;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                    rd_addr      = cmp_idx_reg + 1'b1;
                end
            end
            BK_MISS:
            begin
                res_next.packed_color = word_reg;
                if (is_full)
                begin
                    res_next.color_index  = '0;
                    res_next.newly_added  = 1'b0;
                    res_next.full_error   = 1'b1;
                    res_next.entries_used = USED_OUT_W'(count_reg);
                end
                else
                begin
                    ram_we                = 1'b1;
                    count_next            = count_reg + 1'b1;
                    res_next.color_index  = IDX_OUT_W'(count_reg);
                    res_next.newly_added  = 1'b1;
                    res_next.full_error   = 1'b0;
                    res_next.entries_used = USED_OUT_W'(count_reg + 1'b1);
                end
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(PALETTE_DEPTH))
        else $error("palette count beyond depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("search index past stored entries");

    a_write_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == BK_MISS && !is_full))
        else $error("palette written outside an append");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 && $past(state_reg) == BK_MISS))
        else $error("palette count moved without an append");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result lost or changed");

endmodule

`default_nettype wire

>>> hdl/rgba5551_palette_builder.sv
// Top level of the RGBA5551 palette builder.
`default_nettype none

// Converts RGBA8888 pixels to RGBA5551 words and maps each word to a palette
// index. Each channel is scaled as v*31/255 (truncated); alpha becomes one
// bit, set when nonzero. The palette is searched oldest entry first and the
// first match is reported; a colour not yet present is appended while the
// entry count is below min(palette_max, PALETTE_DEPTH), otherwise full_error
// is raised with color_index zero and nothing stored. Both sides behave as
// queues: a pixel request is taken on push while full is low, and a result
// request is taken on pop while empty is low. A two-entry queue sits between
// the packing front end and the search engine, so pixels keep arriving while
// a search runs, and a result register lets the next search start while a
// result waits to be popped. Throughput is set by the single read port of
// the palette RAM, scanned one entry per cycle: a search compares entries
// up to and including the match on a hit, or every stored entry on a miss,
// and the engine holds a finished result while the previous one is still
// unpopped. palette_max may only be written while idle; reset sets it to
// 256 and empties the palette. Palette RAM contents need no clearing: only
// entries below the count are ever compared.
module rgba5551_palette_builder #(
    parameter int PALETTE_DEPTH = rgbpal_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              palette_max_we,
    input  wire logic [rgbpal_pkg::PMAX_W-1:0]     palette_max_wdata,
    // pixel side
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0]     red,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0]     green,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0]     blue,
    input  wire logic [rgbpal_pkg::CHAN_W-1:0]     alpha,
    // result side
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [rgbpal_pkg::IDX_OUT_W-1:0]       color_index,
    output logic [rgbpal_pkg::WORD_W-1:0]          packed_color,
    output logic                                   newly_added,
    output logic                                   full_error,
    output logic [rgbpal_pkg::USED_OUT_W-1:0]      entries_used
);
    import rgbpal_pkg::*;

    logic [PMAX_W-1:0] palette_max_reg, palette_max_next;

    // front end to queue
    logic              q_push;
    logic [WORD_W-1:0] q_wdata;
    logic              q_full;
    // queue to search engine
    logic              q_pop;
    logic              q_empty;
    logic [WORD_W-1:0] q_rdata;
    res_t              res;

    // configuration register, to be written only while the block is idle; the block does not enforce this
    assign palette_max_next = palette_max_we ? palette_max_wdata : palette_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_max_reg <= PMAX_RESET;
        end
        else
        begin
            palette_max_reg <= palette_max_next;
        end
    end

    // pack pixels into RGBA5551 words
    rgbpal_front u_front (
        .push    (push),
        .full    (full),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .alpha   (alpha),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // decouples packing from the search
    rgbpal_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // search, append and hold the result
    rgbpal_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .palette_max (palette_max_reg),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .res         (res)
    );

    assign color_index  = res.color_index;
    assign packed_color = res.packed_color;
    assign newly_added  = res.newly_added;
    assign full_error   = res.full_error;
    assign entries_used = res.entries_used;

endmodule

`default_nettype wire

>>> verif/tb_rgba5551_palette_builder.sv
// Self-checking testbench for rgba5551_palette_builder: colour mirror, directed and random pixels.
`default_nettype none

module tb_rgba5551_palette_builder;

    timeunit 1ns;
    timeprecision 1ps;

    import rgbpal_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 12;
    // Nothing accepted on either side for this long means the block has hung.
    // The worst honest gap is one full palette scan while the receiver is in
    // its sparse mode, and the limit is set well above that.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet period after the last result, to catch stray extra results.
    localparam int TAIL_CYCLES    = 600;
    // Size of the pool of earlier pixels that random requests re-use.
    localparam int HISTORY_MAX    = 1024;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
    } pixel_t;

    // Receiver behaviour: always ready, coin-toss ready, or sparsely ready.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    // Mirror of the palette: predicts the result of each accepted pixel request
    // and holds the predictions until the block hands the results over.
    class palette_mirror;
        logic [WORD_W-1:0] stored_words [PALETTE_DEPTH_DEF];
        int unsigned       used_count;
        int unsigned       max_entries;
        res_t              pending_lookups [$];
        int unsigned       mismatches;

        function new();
            used_count  = 0;
            max_entries = PMAX_RESET;
            mismatches  = 0;
        endfunction

        function void set_max(logic [PMAX_W-1:0] value);
            max_entries = value;
        endfunction

        function logic [4:0] to_five(logic [CHAN_W-1:0] v);
            int unsigned scaled;
            scaled = v * 31;
            return 5'(scaled / 255);
        endfunction

        function void lookup_pixel(pixel_t px);
            res_t              predicted;
            logic [WORD_W-1:0] word;
            int                hit;
            int unsigned       cap;
            word = {to_five(px.r), to_five(px.g), to_five(px.b), px.a != 0};
            cap  = (max_entries > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : max_entries;
            hit  = -1;
            for (int i = 0; i < used_count; i++)
            begin
                if (hit < 0 && stored_words[i] == word)
                    hit = i;
            end
            predicted.packed_color = word;
            predicted.color_index  = '0;
            predicted.newly_added  = 1'b0;
            predicted.full_error   = 1'b0;
            if (hit >= 0)
                predicted.color_index = 8'(hit);
            else if (used_count >= cap)
                predicted.full_error = 1'b1;
            else
            begin
                stored_words[used_count] = word;
                predicted.color_index    = 8'(used_count);
                predicted.newly_added    = 1'b1;
                used_count++;
            end
            predicted.entries_used = 9'(used_count);
            pending_lookups.push_back(predicted);
        endfunction

        function void compare_result(res_t got);
            res_t want;
            if (pending_lookups.size() == 0)
            begin
                $error("result popped with none outstanding: index %0d colour %h",
                       got.color_index, got.packed_color);
                mismatches++;
                return;
            end
            want = pending_lookups.pop_front();
            if (got.color_index !== want.color_index)
            begin
                $error("color_index: expected %0d, got %0d", want.color_index, got.color_index);
                mismatches++;
            end
            if (got.packed_color !== want.packed_color)
            begin
                $error("packed_color: expected %h, got %h", want.packed_color, got.packed_color);
                mismatches++;
            end
            if (got.newly_added !== want.newly_added)
            begin
                $error("newly_added: expected %b, got %b", want.newly_added, got.newly_added);
                mismatches++;
            end
            if (got.full_error !== want.full_error)
            begin
                $error("full_error: expected %b, got %b", want.full_error, got.full_error);
                mismatches++;
            end
            if (got.entries_used !== want.entries_used)
            begin
                $error("entries_used: expected %0d, got %0d", want.entries_used, got.entries_used);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  palette_max_we = 1'b0;
    logic [PMAX_W-1:0]     palette_max_wdata = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CHAN_W-1:0]     red = '0;
    logic [CHAN_W-1:0]     green = '0;
    logic [CHAN_W-1:0]     blue = '0;
    logic [CHAN_W-1:0]     alpha = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [IDX_OUT_W-1:0]  color_index;
    logic [WORD_W-1:0]     packed_color;
    logic                  newly_added;
    logic                  full_error;
    logic [USED_OUT_W-1:0] entries_used;

    palette_mirror mirror = new();
    pixel_t        seen_pixels [$];
    int            burst_left = 0;
    int            idle_cycles = 0;
    rx_mode_t      rx_mode = RX_STEADY;
    int            rx_mode_left = 0;
    int unsigned   rx_tick = 0;

    rgba5551_palette_builder dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .palette_max_we    (palette_max_we),
        .palette_max_wdata (palette_max_wdata),
        .push              (push),
        .full              (full),
        .red               (red),
        .green             (green),
        .blue              (blue),
        .alpha             (alpha),
        .empty             (empty),
        .pop               (pop),
        .color_index       (color_index),
        .packed_color      (packed_color),
        .newly_added       (newly_added),
        .full_error        (full_error),
        .entries_used      (entries_used)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Result side. Outputs are read just after the rising edge, so they still
    // hold the values the block presented at that edge. The pop pattern moves
    // between modes so stalls land on every stage of a search, with long
    // stretches of no stalling in between.
    always @(posedge clk)
    begin : result_side
        res_t on_ports;
        if (rst_n && pop && !empty)
        begin
            on_ports.color_index  = color_index;
            on_ports.packed_color = packed_color;
            on_ports.newly_added  = newly_added;
            on_ports.full_error   = full_error;
            on_ports.entries_used = entries_used;
            mirror.compare_result(on_ports);
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(RX_STEADY, RX_SPARSE));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_STEADY: pop <= 1'b1;
            RX_RANDOM: pop <= 1'($urandom_range(0, 1));
            default:   pop <= (rx_tick % 5 == 0);
        endcase
    end

    // Hang detector: counts cycles in which neither side moves a request.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic pixel_t mk_pixel(int r, int g, int b, int a);
        pixel_t px;
        px = {8'(r), 8'(g), 8'(b), 8'(a)};
        return px;
    endfunction

    // Offers one pixel request and returns once it has been taken. Entered
    // just after a rising edge. Bursts of random length are separated by
    // random gaps; a zero gap keeps push high straight through.
    task automatic send_pixel(input pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
        end
        push  <= 1'b1;
        red   <= px.r;
        green <= px.g;
        blue  <= px.b;
        alpha <= px.a;
        do
            @(posedge clk);
        while (full);
        mirror.lookup_pixel(px);
        burst_left--;
    endtask

    // Stops pushing and waits for every outstanding result to be popped.
    task automatic drain_results();
        push <= 1'b0;
        burst_left = 0;
        while (mirror.pending_lookups.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // palette_max is only touched with the block idle.
    task automatic write_palette_max(input logic [PMAX_W-1:0] value);
        drain_results();
        palette_max_we    <= 1'b1;
        palette_max_wdata <= value;
        @(posedge clk);
        palette_max_we    <= 1'b0;
        mirror.set_max(value);
    endtask

    // Random pixels: mostly re-used earlier pixels (hits anywhere in the
    // palette, alpha sometimes changed to another opaque value), the rest
    // fresh colours that either allocate or overflow.
    task automatic random_phase(input logic [PMAX_W-1:0] limit, input int count);
        pixel_t px;
        write_palette_max(limit);
        repeat (count)
        begin
            if (seen_pixels.size() != 0 && $urandom_range(0, 9) < 6)
            begin
                px = seen_pixels[$urandom_range(0, seen_pixels.size() - 1)];
                if (px.a != 0 && $urandom_range(0, 3) == 0)
                    px.a = 8'($urandom_range(1, 255));
            end
            else
            begin
                px = pixel_t'($urandom);
                if ($urandom_range(0, 4) == 0)
                    px.a = '0;
                seen_pixels.push_back(px);
                if (seen_pixels.size() > HISTORY_MAX)
                    void'(seen_pixels.pop_front());
            end
            send_pixel(px);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Maximum of zero: every colour is absent and the palette is full.
        write_palette_max(9'd0);
        send_pixel(mk_pixel(0, 0, 0, 0));
        send_pixel(mk_pixel(255, 255, 255, 255));

        // One entry: first colour allocates, any other overflows, the
        // stored one still matches with a different opaque alpha.
        write_palette_max(9'd1);
        send_pixel(mk_pixel(255, 255, 255, 255));
        send_pixel(mk_pixel(0, 0, 0, 0));
        send_pixel(mk_pixel(255, 254, 255, 1));
        send_pixel(mk_pixel(255, 255, 255, 128));

        // Scaling edges: 8 truncates to zero, 9 to one, 17 to two.
        write_palette_max(9'd4);
        send_pixel(mk_pixel(0, 0, 0, 0));
        send_pixel(mk_pixel(8, 8, 8, 0));
        send_pixel(mk_pixel(9, 9, 9, 0));
        send_pixel(mk_pixel(0, 0, 0, 1));
        send_pixel(mk_pixel(17, 0, 0, 0));
        send_pixel(mk_pixel(9, 0, 0, 0));
        send_pixel(mk_pixel(0, 0, 255, 0));

        // Random phases: a small limit, a limit above capacity, a limit
        // lowered below the count, the full capacity, then a limit of one.
        random_phase(9'd40, 300);
        random_phase(9'd511, 350);
        random_phase(9'd100, 300);
        random_phase(9'd256, 700);
        random_phase(9'd1, 290);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending_lookups.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
